// ===== hw/rtl/shash_pkg.sv =====
// Shared types, constants and round functions for the streaming SHA-256 core.
// Used by sha256_stream_hash_core; depends on nothing else.
`default_nettype none

package shash_pkg;

    localparam int WORD_W      = 32;
    localparam int HASH_WORDS  = 8;
    localparam int BLOCK_WORDS = 16;
    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 64;
    localparam int HASH_AW     = $clog2(HASH_WORDS);
    localparam int BLOCK_AW    = $clog2(BLOCK_WORDS);
    localparam int BYTE_AW     = $clog2(BLOCK_BYTES);
    localparam int ROUND_AW    = $clog2(ROUNDS);

    // Padding marker and the byte offset at which the length field starts.
    localparam logic [7:0]         PAD_BYTE  = 8'h80;
    localparam logic [BYTE_AW-1:0] LEN_START = BYTE_AW'(56);

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic       byte_present;
        logic [7:0] message_byte;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [63:0] digest_part;
        logic        part_last;
    } result_t;

    localparam word_t H_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(word_t x, int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t big_sigma0(word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t choose(word_t e, word_t f, word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(word_t a, word_t b, word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/shash_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependency.
`default_nettype none

module shash_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sha256_stream_hash_core.sv =====
// Streaming SHA-256 core: byte intake, padding, block compression and digest output.
// Depends on shash_pkg and shash_ram.
`default_nettype none

// The core hashes a byte stream, one byte per input transfer. A transfer with
// end_of_message set closes the message (its byte, if present, is absorbed first);
// a bare end mark with no byte is allowed, so an empty message is legal. The core
// then pads the message, finishes the hash and delivers the 256-bit digest as four
// 64-bit transfers, most significant part first, with part_last on the fourth, and
// is ready for the next message with the initial hash values. A byte that does not
// fill a block is taken without a stall. A byte that fills the 64-byte block stalls
// the input while the block and the chaining value are streamed out of the two RAMs
// into the schedule window and working registers, the single round unit runs the 64
// rounds, and the result is added back into the hash RAM. An end mark brings padding
// writes plus one or two such compressions, after which each digest part is read
// from the hash RAM and sent, waiting while the output is stalled. The last part may
// wait in the output register while the next message already streams in. No
// clearing pass is needed after reset.
module sha256_stream_hash_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  shash_pkg::item_t   item_data,
    output logic              result_valid,
    input  logic              result_stall,
    output shash_pkg::result_t result_data
);

    import shash_pkg::*;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PAD    = 6'b000010,
        ST_LOAD   = 6'b000100,
        ST_ROUND  = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    // Steps of one digest part: read the high word, read the low word, send.
    localparam logic [1:0] STEP_HI   = 2'd0;
    localparam logic [1:0] STEP_LO   = 2'd1;
    localparam logic [1:0] STEP_SEND = 2'd2;

    localparam int PART_W = HASH_AW - 1;

    localparam logic [ROUND_AW-1:0] LOAD_LAST   = ROUND_AW'(BLOCK_WORDS);
    localparam logic [ROUND_AW-1:0] ROUND_LAST  = ROUND_AW'(ROUNDS - 1);
    localparam logic [ROUND_AW-1:0] UPDATE_LAST = ROUND_AW'(HASH_WORDS);
    localparam logic [ROUND_AW-1:0] HASH_CNT    = ROUND_AW'(HASH_WORDS);
    localparam logic [BYTE_AW-1:0]  FILL_LAST   = BYTE_AW'(BLOCK_BYTES - 1);
    localparam logic [BLOCK_AW-1:0] IDX_LEN_HI  = BLOCK_AW'(BLOCK_WORDS - 2);
    localparam logic [BLOCK_AW-1:0] IDX_LEN_LO  = BLOCK_AW'(BLOCK_WORDS - 1);
    localparam logic [PART_W-1:0]   LAST_PART   = '1;

    // Control state.
    state_t              state_reg, state_next;
    logic [ROUND_AW-1:0] cnt_reg, cnt_next;
    logic [BYTE_AW-1:0]  fill_reg, fill_next;
    logic [63:0]         bits_reg, bits_next;
    // While set, the hash RAM is taken to hold the initial hash values.
    logic                hash_init_reg, hash_init_next;
    // Follow-up work after the current compression.
    logic                end_pend_reg, end_pend_next;
    logic                pad_more_reg, pad_more_next;
    logic                final_reg, final_next;
    logic [BLOCK_AW-1:0] pad_idx_reg, pad_idx_next;
    logic                pad_first_reg, pad_first_next;
    logic                pad_two_reg, pad_two_next;
    logic                pad_second_reg, pad_second_next;
    logic [PART_W-1:0]   part_reg, part_next;
    logic [1:0]          step_reg, step_next;
    logic [HASH_AW-1:0]  haddr_reg;
    logic                result_valid_reg, result_valid_next;

    // Datapath registers.
    logic [23:0]         acc_reg, acc_next;
    word_t               w_reg [BLOCK_WORDS];
    word_t               w_next [BLOCK_WORDS];
    word_t               v_reg [HASH_WORDS];
    word_t               v_next [HASH_WORDS];
    word_t               hi_reg, hi_next;
    result_t             result_reg, result_next;

    // RAM ports.
    logic                blk_we;
    logic [BLOCK_AW-1:0] blk_waddr;
    word_t               blk_wdata;
    logic [BLOCK_AW-1:0] blk_raddr;
    word_t               blk_rdata;
    logic                hash_we;
    logic [HASH_AW-1:0]  hash_waddr;
    word_t               hash_wdata;
    logic [HASH_AW-1:0]  hash_raddr;
    word_t               hash_rdata;

    logic                item_accept;
    logic                result_free;
    word_t               hash_rd;
    word_t               pad_word;
    word_t               round_t1;
    word_t               round_t2;
    word_t               sched_new;
    logic [BYTE_AW-1:0]  fill_now;

    shash_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLOCK_WORDS)
    ) u_block_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    shash_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HASH_WORDS)
    ) u_hash_ram (
        .clk   (clk),
        .we    (hash_we),
        .waddr (hash_waddr),
        .wdata (hash_wdata),
        .raddr (hash_raddr),
        .rdata (hash_rdata)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign result_free  = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // Right after reset or a finished message the hash RAM content is stale, and
    // the initial hash values stand in for it until the first write-back completes.
    assign hash_rd = hash_init_reg ? H_INIT[haddr_reg] : hash_rdata;

    // One SHA-256 round on the working registers, and the next schedule word.
    assign round_t1 = v_reg[7] + big_sigma1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
                    + ROUND_K[cnt_reg] + w_reg[0];
    assign round_t2 = big_sigma0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);
    assign sched_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);

    // Word written during padding. The first word merges the pending bytes of the
    // partial word with the marker byte; the last two words of the final block carry
    // the big-endian bit count; all other words are zero.
    always_comb
    begin
        pad_word = '0;
        if (pad_first_reg)
        begin
            case (fill_reg[1:0])
                2'd0:    pad_word = {PAD_BYTE, 24'h0};
                2'd1:    pad_word = {acc_reg[7:0], PAD_BYTE, 16'h0};
                2'd2:    pad_word = {acc_reg[15:0], PAD_BYTE, 8'h0};
                2'd3:    pad_word = {acc_reg[23:0], PAD_BYTE};
                default: pad_word = '0;
            endcase
        end
        else if (!pad_two_reg || pad_second_reg)
        begin
            if (pad_idx_reg == IDX_LEN_HI)
            begin
                pad_word = bits_reg[63:32];
            end
            else if (pad_idx_reg == IDX_LEN_LO)
            begin
                pad_word = bits_reg[31:0];
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        fill_next         = fill_reg;
        bits_next         = bits_reg;
        hash_init_next    = hash_init_reg;
        end_pend_next     = end_pend_reg;
        pad_more_next     = pad_more_reg;
        final_next        = final_reg;
        pad_idx_next      = pad_idx_reg;
        pad_first_next    = pad_first_reg;
        pad_two_next      = pad_two_reg;
        pad_second_next   = pad_second_reg;
        part_next         = part_reg;
        step_next         = step_reg;
        acc_next          = acc_reg;
        hi_next           = hi_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        w_next            = w_reg;
        v_next            = v_reg;
        fill_now          = fill_reg;

        blk_we     = 1'b0;
        blk_waddr  = pad_idx_reg;
        blk_wdata  = pad_word;
        blk_raddr  = cnt_reg[BLOCK_AW-1:0];
        hash_we    = 1'b0;
        hash_waddr = HASH_AW'(cnt_reg - ROUND_AW'(1));
        hash_wdata = hash_rd + v_reg[0];
        hash_raddr = cnt_reg[HASH_AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (item_data.byte_present)
                    begin
                        acc_next  = {acc_reg[15:0], item_data.message_byte};
                        bits_next = bits_reg + 64'd8;
                        fill_now  = fill_reg + BYTE_AW'(1);
                        // A complete word goes into the block RAM.
                        if (fill_reg[1:0] == 2'd3)
                        begin
                            blk_we    = 1'b1;
                            blk_waddr = fill_reg[BYTE_AW-1:2];
                            blk_wdata = {acc_reg[23:0], item_data.message_byte};
                        end
                    end
                    fill_next = fill_now;
                    if (item_data.byte_present && fill_reg == FILL_LAST)
                    begin
                        state_next    = ST_LOAD;
                        cnt_next      = '0;
                        end_pend_next = item_data.end_of_message;
                    end
                    else if (item_data.end_of_message)
                    begin
                        state_next      = ST_PAD;
                        pad_idx_next    = fill_now[BYTE_AW-1:2];
                        pad_first_next  = 1'b1;
                        pad_two_next    = (fill_now >= LEN_START);
                        pad_second_next = 1'b0;
                    end
                end
            end

            ST_PAD:
            begin
                blk_we         = 1'b1;
                pad_first_next = 1'b0;
                if (pad_idx_reg == IDX_LEN_LO)
                begin
                    state_next    = ST_LOAD;
                    cnt_next      = '0;
                    final_next    = !pad_two_reg || pad_second_reg;
                    pad_more_next = pad_two_reg && !pad_second_reg;
                end
                else
                begin
                    pad_idx_next = pad_idx_reg + BLOCK_AW'(1);
                end
            end

            ST_LOAD:
            begin
                // Read data arrives in the cycle after its address is given.
                if (cnt_reg != '0)
                begin
                    for (int i = 0; i < BLOCK_WORDS - 1; i++)
                    begin
                        w_next[i] = w_reg[i + 1];
                    end
                    w_next[BLOCK_WORDS - 1] = blk_rdata;
                    if (cnt_reg <= HASH_CNT)
                    begin
                        for (int i = 0; i < HASH_WORDS - 1; i++)
                        begin
                            v_next[i] = v_reg[i + 1];
                        end
                        v_next[HASH_WORDS - 1] = hash_rd;
                    end
                end
                if (cnt_reg == LOAD_LAST)
                begin
                    state_next = ST_ROUND;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + ROUND_AW'(1);
                end
            end

            ST_ROUND:
            begin
                v_next[0] = round_t1 + round_t2;
                v_next[1] = v_reg[0];
                v_next[2] = v_reg[1];
                v_next[3] = v_reg[2];
                v_next[4] = v_reg[3] + round_t1;
                v_next[5] = v_reg[4];
                v_next[6] = v_reg[5];
                v_next[7] = v_reg[6];
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[BLOCK_WORDS - 1] = sched_new;
                if (cnt_reg == ROUND_LAST)
                begin
                    state_next = ST_UPDATE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + ROUND_AW'(1);
                end
            end

            ST_UPDATE:
            begin
                // Read word n, then add the working value and write it back.
                if (cnt_reg != '0)
                begin
                    hash_we = 1'b1;
                    for (int i = 0; i < HASH_WORDS - 1; i++)
                    begin
                        v_next[i] = v_reg[i + 1];
                    end
                end
                if (cnt_reg == UPDATE_LAST)
                begin
                    hash_init_next = 1'b0;
                    cnt_next       = '0;
                    if (final_reg)
                    begin
                        state_next = ST_OUT;
                        final_next = 1'b0;
                        part_next  = '0;
                        step_next  = STEP_HI;
                    end
                    else if (pad_more_reg)
                    begin
                        state_next      = ST_PAD;
                        pad_more_next   = 1'b0;
                        pad_idx_next    = '0;
                        pad_first_next  = 1'b0;
                        pad_second_next = 1'b1;
                    end
                    else if (end_pend_reg)
                    begin
                        // The end mark came with the byte that filled the block.
                        state_next      = ST_PAD;
                        end_pend_next   = 1'b0;
                        pad_idx_next    = '0;
                        pad_first_next  = 1'b1;
                        pad_two_next    = 1'b0;
                        pad_second_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + ROUND_AW'(1);
                end
            end

            ST_OUT:
            begin
                hash_raddr = {part_reg, (step_reg == STEP_LO)};
                case (step_reg)
                    STEP_HI:
                    begin
                        if (result_free)
                        begin
                            step_next = STEP_LO;
                        end
                    end
                    STEP_LO:
                    begin
                        hi_next   = hash_rd;
                        step_next = STEP_SEND;
                    end
                    STEP_SEND:
                    begin
                        result_next.digest_part = {hi_reg, hash_rd};
                        result_next.part_last   = (part_reg == LAST_PART);
                        result_valid_next       = 1'b1;
                        step_next               = STEP_HI;
                        if (part_reg == LAST_PART)
                        begin
                            // Start the next message from the initial hash values.
                            state_next     = ST_IDLE;
                            hash_init_next = 1'b1;
                            fill_next      = '0;
                            bits_next      = '0;
                        end
                        else
                        begin
                            part_next = part_reg + PART_W'(1);
                        end
                    end
                    default:
                    begin
                        step_next = STEP_HI;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            fill_reg         <= '0;
            bits_reg         <= '0;
            hash_init_reg    <= 1'b1;
            end_pend_reg     <= 1'b0;
            pad_more_reg     <= 1'b0;
            final_reg        <= 1'b0;
            pad_idx_reg      <= '0;
            pad_first_reg    <= 1'b0;
            pad_two_reg      <= 1'b0;
            pad_second_reg   <= 1'b0;
            part_reg         <= '0;
            step_reg         <= STEP_HI;
            haddr_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            fill_reg         <= fill_next;
            bits_reg         <= bits_next;
            hash_init_reg    <= hash_init_next;
            end_pend_reg     <= end_pend_next;
            pad_more_reg     <= pad_more_next;
            final_reg        <= final_next;
            pad_idx_reg      <= pad_idx_next;
            pad_first_reg    <= pad_first_next;
            pad_two_reg      <= pad_two_next;
            pad_second_reg   <= pad_second_next;
            part_reg         <= part_next;
            step_reg         <= step_next;
            haddr_reg        <= hash_raddr;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        w_reg      <= w_next;
        v_reg      <= v_next;
        hi_reg     <= hi_next;
        result_reg <= result_next;
    end

    // A new result only comes out of the digest read-out.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside digest read-out");

    // The digest is read from the RAM, never from the initial-value substitute.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> !hash_init_reg)
        else $error("digest read while hash RAM marked as initial");

    // A block taken in from the stream is compressed only when it is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next == ST_LOAD) |-> (fill_next == '0))
        else $error("compression started on a partial block");

    // The block RAM is written only by byte intake and padding.
    assert property (@(posedge clk) disable iff (!rst_n)
        blk_we |-> (state_reg == ST_IDLE || state_reg == ST_PAD))
        else $error("block RAM written during compression or read-out");

endmodule

`default_nettype wire
